### sv/mwnco_pkg.sv
`timescale 1ns / 1ps

package mwnco_pkg;

    // default widths
    localparam int PHASE_BITS_DEF     = 32;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int SINE_ADDR_BITS_DEF = 10;

    // waveform value is Q1.15 spanning [-1.0, +1.0], so one extra bit
    localparam int WAVE_W = 17;
    // amplitude widened to a signed operand
    localparam int AMP_W  = 17;
    localparam int PROD_W = WAVE_W + AMP_W;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    // stages in the back end that hold a beat: table read, multiply, output
    localparam int BACK_STAGES = 3;

    // configuration port
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE   = 2'd1;
    localparam logic [1:0] REG_WAVE_SELECT = 2'd2;
    localparam logic [1:0] REG_PULSE_LIMIT = 2'd3;

    // register reset values
    localparam logic [31:0] PHASE_STEP_RST  = 32'd39370534;
    localparam logic [15:0] AMPLITUDE_RST   = 16'd16384;
    localparam logic [1:0]  WAVE_SELECT_RST = 2'd1;
    localparam logic [31:0] PULSE_LIMIT_RST = 32'd1073741824;

    // waveform codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd2;
    localparam logic [1:0] WAVE_PULSE    = 2'd3;

    // Q30 Taylor coefficients of sin(pi/2 * u), odd terms up to degree 11
    localparam logic [63:0] SIN_C1  = 64'd1686629713;
    localparam logic [63:0] SIN_C3  = 64'd693598668;
    localparam logic [63:0] SIN_C5  = 64'd85569306;
    localparam logic [63:0] SIN_C7  = 64'd5026995;
    localparam logic [63:0] SIN_C9  = 64'd172272;
    localparam logic [63:0] SIN_C11 = 64'd3864;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [15:0] amplitude;
        logic [1:0]  wave_select;
        logic [31:0] pulse_limit;
    } t_cfg;

    // truncating Q30 multiply
    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    // quarter-wave table entry: round(32767 * sin(pi/2 * (a + 0.5) / 2^addr_bits))
    function automatic logic [15:0] sine_entry(input int unsigned a,
                                               input int unsigned addr_bits);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        logic [63:0] s;
        u  = 64'(2 * a + 1) << (29 - addr_bits);
        u2 = mul_q30(u, u);
        r  = SIN_C11;
        r  = SIN_C9 - mul_q30(r, u2);
        r  = SIN_C7 - mul_q30(r, u2);
        r  = SIN_C5 - mul_q30(r, u2);
        r  = SIN_C3 - mul_q30(r, u2);
        r  = SIN_C1 - mul_q30(r, u2);
        r  = mul_q30(r, u);
        s  = (r * 64'd32767 + (64'd1 << 29)) >> 30;
        return s[15:0];
    endfunction

endpackage

### sv/mwnco_if.sv
`timescale 1ns / 1ps

// tick channel
interface mwnco_req_if;
    logic valid;
    logic ready;
    logic sample_request;

    modport source (output valid, output sample_request, input ready);
    modport sink   (input valid, input sample_request, output ready);
endinterface

// sample channel
interface mwnco_smp_if #(
    parameter int SAMPLE_BITS = mwnco_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### sv/mwnco_queue.sv
`timescale 1ns / 1ps

module mwnco_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = mwnco_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### sv/mwnco_front.sv
`timescale 1ns / 1ps

module mwnco_front #(
    parameter int PHASE_BITS = mwnco_pkg::PHASE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mwnco_pkg::t_cfg     i_cfg,
    input  logic                i_req_valid,
    input  logic                i_req_bit,
    output logic                o_req_ready,
    output logic                o_push_valid,
    output logic [PHASE_BITS:0] o_push_data,
    input  logic                i_push_ready
);

    localparam int CMP_W = (PHASE_BITS > 32) ? PHASE_BITS : 32;

    logic [PHASE_BITS-1:0]    r_phase, n_phase;
    logic [PHASE_BITS+31:0]   step_wide;
    logic [PHASE_BITS-1:0]    step;
    logic [CMP_W-1:0]         phase_al;
    logic [CMP_W-1:0]         limit_al;
    logic                     pulse_hi;
    logic                     tick;

    assign o_req_ready = i_push_ready;
    assign tick        = i_req_valid && i_push_ready && i_req_bit;

    // step scaled to the accumulator width: step * 2^(PHASE_BITS-32)
    assign step_wide = {i_cfg.phase_step, {PHASE_BITS{1'b0}}} >> 32;
    assign step      = step_wide[PHASE_BITS-1:0];

    // pulse level: phase and limit compared as left-aligned turn fractions
    assign phase_al = CMP_W'(r_phase) << (CMP_W - PHASE_BITS);
    assign limit_al = CMP_W'(i_cfg.pulse_limit) << (CMP_W - 32);
    assign pulse_hi = (phase_al < limit_al);

    assign o_push_valid = i_req_valid && i_req_bit;
    assign o_push_data  = {pulse_hi, r_phase};

    // phase accumulator, wraps at one turn
    assign n_phase = tick ? r_phase + step : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

### sv/mwnco_back.sv
`timescale 1ns / 1ps

module mwnco_back #(
    parameter int PHASE_BITS     = mwnco_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS    = mwnco_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_ADDR_BITS = mwnco_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mwnco_pkg::t_cfg               i_cfg,
    input  logic                          i_pop_valid,
    input  logic [PHASE_BITS:0]           i_pop_data,
    output logic                          o_pop_ready,
    output logic                          o_smp_valid,
    output logic signed [SAMPLE_BITS-1:0] o_smp_data,
    input  logic                          i_smp_ready
);

    localparam int ROM_SIZE = 1 << SINE_ADDR_BITS;
    localparam int WAVE_W   = mwnco_pkg::WAVE_W;
    localparam int AMP_W    = mwnco_pkg::AMP_W;
    localparam int PROD_W   = mwnco_pkg::PROD_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int SHIFT    = 31 - SAMPLE_BITS;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -SAT_HI - 1;
    localparam logic signed [WAVE_W-1:0] FULL_POS  = WAVE_W'(32768);
    localparam logic signed [WAVE_W-1:0] FULL_NEG  = -FULL_POS;

    typedef logic [15:0] t_sine_rom [ROM_SIZE];

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int a = 0; a < ROM_SIZE; a++) begin
            rom[a] = mwnco_pkg::sine_entry(a, SINE_ADDR_BITS);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic                      en;
    logic [PHASE_BITS-1:0]     phase;
    logic                      pulse_hi;
    logic [1:0]                quad;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [15:0]               h;
    logic signed [WAVE_W-1:0]  d;
    logic signed [WAVE_W-1:0]  d_abs;
    logic signed [WAVE_W-1:0]  n_lin;

    logic                      r_s1_valid;
    logic                      r_s1_sine;
    logic                      r_s1_neg;
    logic [15:0]               r_s1_rom;
    logic signed [WAVE_W-1:0]  r_s1_lin;

    logic signed [WAVE_W-1:0]  rom_s;
    logic signed [WAVE_W-1:0]  w_sel;
    logic signed [AMP_W-1:0]   amp_s;
    logic signed [PROD_W-1:0]  n_prod;
    logic                      r_s2_valid;
    logic signed [PROD_W-1:0]  r_s2_prod;

    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   scaled;
    logic signed [SUM_W-1:0]   clamped;
    logic                      r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;

    // whole back end advances unless the output register is held
    assign en          = !r_out_valid || i_smp_ready;
    assign o_pop_ready = en;

    // stage 1: table read and the linear waveforms
    assign phase    = i_pop_data[PHASE_BITS-1:0];
    assign pulse_hi = i_pop_data[PHASE_BITS];
    assign quad     = phase[PHASE_BITS-1 -: 2];
    assign idx      = quad[0] ? ~phase[PHASE_BITS-3 -: SINE_ADDR_BITS]
                              : phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
    assign h        = phase[PHASE_BITS-1 -: 16];
    assign d        = $signed({1'b0, h}) - FULL_POS;
    assign d_abs    = (d < 0) ? -d : d;

    always_comb begin
        case (i_cfg.wave_select)
            mwnco_pkg::WAVE_TRIANGLE: n_lin = WAVE_W'((d_abs <<< 1) - FULL_POS);
            mwnco_pkg::WAVE_SAWTOOTH: n_lin = d;
            mwnco_pkg::WAVE_PULSE:    n_lin = pulse_hi ? FULL_POS : FULL_NEG;
            default:                  n_lin = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_pop_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sine <= (i_cfg.wave_select == mwnco_pkg::WAVE_SINE);
            r_s1_neg  <= quad[1];
            r_s1_rom  <= SINE_ROM[idx];
            r_s1_lin  <= n_lin;
        end
    end

    // stage 2: sign of the sine half turn, then gain
    assign rom_s  = $signed({1'b0, r_s1_rom});
    assign w_sel  = r_s1_sine ? (r_s1_neg ? -rom_s : rom_s) : r_s1_lin;
    assign amp_s  = $signed({1'b0, i_cfg.amplitude});
    assign n_prod = w_sel * amp_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_prod <= n_prod;
        end
    end

    // stage 3: round half up, saturate, output register
    assign sum    = SUM_W'(r_s2_prod) + ROUND_BIAS;
    assign scaled = sum >>> SHIFT;

    always_comb begin
        if (scaled > SAT_HI) begin
            clamped = SAT_HI;
        end else if (scaled < SAT_LO) begin
            clamped = SAT_LO;
        end else begin
            clamped = scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_sample <= clamped[SAMPLE_BITS-1:0];
        end
    end

    assign o_smp_valid = r_out_valid;
    assign o_smp_data  = r_out_sample;

endmodule

### sv/multi_waveform_nco_top.sv
`timescale 1ns / 1ps

// Numerically controlled oscillator. Every tick beat with sample_request set
// yields one signed Q1.15 sample of the selected waveform (sine from a
// quarter-wave table, triangle, sawtooth or pulse) at the current phase,
// scaled by amplitude with round half up and saturation, and then advances
// the phase by phase_step; a beat with sample_request clear is taken and
// yields nothing. One tick is taken every clock cycle while the queue has
// room: the phase add is the only dependence from one tick to the next. A
// sample is held while the sample channel stalls; a four-entry queue between
// the phase front and the waveform back end keeps ticks flowing while results
// wait. Registers sit on the APB port at byte addresses 0 (phase_step), 4
// (amplitude), 8 (wave_select) and 12 (pulse_limit); the user must write them
// only while the block is idle, and the block does not enforce it.
module multi_waveform_nco_top #(
    parameter int PHASE_BITS     = mwnco_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS    = mwnco_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_ADDR_BITS = mwnco_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    mwnco_req_if.sink                            i_req,
    mwnco_smp_if.source                          o_smp,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mwnco_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [mwnco_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [mwnco_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                 pready
);

    mwnco_pkg::t_cfg     r_cfg;
    logic [1:0]          reg_idx;
    logic                cfg_wr;
    logic                push_valid;
    logic                push_ready;
    logic [PHASE_BITS:0] push_data;
    logic                pop_valid;
    logic                pop_ready;
    logic [PHASE_BITS:0] pop_data;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step  <= mwnco_pkg::PHASE_STEP_RST;
            r_cfg.amplitude   <= mwnco_pkg::AMPLITUDE_RST;
            r_cfg.wave_select <= mwnco_pkg::WAVE_SELECT_RST;
            r_cfg.pulse_limit <= mwnco_pkg::PULSE_LIMIT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                mwnco_pkg::REG_PHASE_STEP:  r_cfg.phase_step  <= pwdata;
                mwnco_pkg::REG_AMPLITUDE:   r_cfg.amplitude   <= pwdata[15:0];
                mwnco_pkg::REG_WAVE_SELECT: r_cfg.wave_select <= pwdata[1:0];
                mwnco_pkg::REG_PULSE_LIMIT: r_cfg.pulse_limit <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            mwnco_pkg::REG_PHASE_STEP:  prdata = r_cfg.phase_step;
            mwnco_pkg::REG_AMPLITUDE:   prdata = 32'(r_cfg.amplitude);
            mwnco_pkg::REG_WAVE_SELECT: prdata = 32'(r_cfg.wave_select);
            mwnco_pkg::REG_PULSE_LIMIT: prdata = r_cfg.pulse_limit;
            default:                    prdata = '0;
        endcase
    end

    // phase front
    mwnco_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req_valid  (i_req.valid),
        .i_req_bit    (i_req.sample_request),
        .o_req_ready  (i_req.ready),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    // tick queue
    mwnco_queue #(
        .WIDTH (PHASE_BITS + 1),
        .DEPTH (mwnco_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    // waveform back end
    mwnco_back #(
        .PHASE_BITS     (PHASE_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_smp_valid (o_smp.valid),
        .o_smp_data  (o_smp.sample_out),
        .i_smp_ready (o_smp.ready)
    );

endmodule

### sv/mwnco_checker.sv
`timescale 1ns / 1ps

module mwnco_checker #(
    parameter int SAMPLE_BITS = mwnco_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_req,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_out_sample
);

    localparam int MAX_PENDING = mwnco_pkg::QUEUE_DEPTH + mwnco_pkg::BACK_STAGES;
    localparam int PEND_W      = $clog2(MAX_PENDING + 2);

    logic [PEND_W-1:0] r_pending, n_pending;
    logic              tick_beat;
    logic              out_beat;

    assign tick_beat = i_in_valid && i_in_ready && i_in_req;
    assign out_beat  = i_out_valid && i_out_ready;

    // ticks taken whose sample has not yet left
    always_comb begin
        n_pending = r_pending;
        if (tick_beat && !out_beat) begin
            n_pending = r_pending + 1'b1;
        end else if (out_beat && !tick_beat) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // a held sample beat keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample))
        else $error("sample beat changed while stalled");

    // no sample without an outstanding tick
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != '0)
        else $error("sample beat without a pending tick");

    // in-flight ticks bounded by queue plus back-end stages
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(MAX_PENDING))
        else $error("more ticks in flight than the design can hold");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("sample beat valid right after reset");

endmodule

bind multi_waveform_nco_top mwnco_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mwnco_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_req     (i_req.sample_request),
    .i_out_valid  (o_smp.valid),
    .i_out_ready  (o_smp.ready),
    .i_out_sample (o_smp.sample_out)
);

### tb/multi_waveform_nco_top_tb.sv
`timescale 1ns / 1ps

module multi_waveform_nco_top_tb;

    // odd Taylor terms of sin(pi/2 * u) in Q30, highest order last
    localparam logic [63:0] TAYLOR_C1  = 64'd1686629713;
    localparam logic [63:0] TAYLOR_C3  = 64'd693598668;
    localparam logic [63:0] TAYLOR_C5  = 64'd85569306;
    localparam logic [63:0] TAYLOR_C7  = 64'd5026995;
    localparam logic [63:0] TAYLOR_C9  = 64'd172272;
    localparam logic [63:0] TAYLOR_C11 = 64'd3864;

    localparam int TABLE_SIZE   = 1024;
    localparam int DRAIN_SLACK  = 12;    // more than the back end stages plus the queue
    localparam int SETTLE_LIMIT = 5000;
    localparam int REPORT_MAX   = 10;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [mwnco_pkg::CFG_ADDR_BITS-1:0] paddr;
    logic [mwnco_pkg::CFG_DATA_BITS-1:0] pwdata;
    logic [mwnco_pkg::CFG_DATA_BITS-1:0] prdata;
    logic pready;

    mwnco_req_if req_if ();
    mwnco_smp_if smp_if ();

    multi_waveform_nco_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_smp   (smp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // oscillator shadow: register copy, phase and quarter-wave table
    mwnco_pkg::t_cfg nco_cfg;
    logic [31:0]     phase_acc;
    int              sine_quarter [TABLE_SIZE];

    logic                pending_ticks    [$];
    logic signed [15:0]  expected_samples [$];

    bit send_gaps;
    bit recv_stalls;
    int send_wait;
    int recv_wait;
    int mismatch_count;
    int sample_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // waveform level at a phase, times gain, rounded half up and clipped
    function automatic logic signed [15:0] predict_sample(input logic [31:0] ph);
        int          level;
        int unsigned idx;
        longint      prod;
        longint      rounded;
        case (nco_cfg.wave_select)
            mwnco_pkg::WAVE_SINE: begin
                idx = ph[29:20];
                if (ph[30]) idx = TABLE_SIZE - 1 - idx;
                level = sine_quarter[idx];
                if (ph[31]) level = -level;
            end
            mwnco_pkg::WAVE_TRIANGLE: begin
                level = int'(ph[31:16]) - 32768;
                if (level < 0) level = -level;
                level = 2 * level - 32768;
            end
            mwnco_pkg::WAVE_SAWTOOTH: level = int'(ph[31:16]) - 32768;
            default: level = (ph < nco_cfg.pulse_limit) ? 32768 : -32768;
        endcase
        prod = longint'(level) * longint'(nco_cfg.amplitude);
        rounded = (prod + 16384) >>> 15;
        if (rounded > 32767) rounded = 32767;
        if (rounded < -32768) rounded = -32768;
        return 16'(rounded);
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: sample %0d %s: expected %0d, got %0d",
                     $realtime, sample_count, what, want, got);
    endtask

    // tick driver: one beat per pending entry, random gap after each when send_gaps is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (req_if.valid && req_if.ready && req_if.sample_request) begin
                expected_samples.push_back(predict_sample(phase_acc));
                phase_acc = phase_acc + nco_cfg.phase_step;
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    req_if.valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    req_if.valid <= 1'b1;
                    req_if.sample_request <= pending_ticks.pop_front();
                    send_wait = send_gaps ? $urandom_range(0, 3) : 0;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor: check each beat, then stall for a random count when recv_stalls is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                if (expected_samples.size() == 0) begin
                    flag_mismatch("with none pending", 0, smp_if.sample_out);
                end else if (smp_if.sample_out !== expected_samples[0]) begin
                    flag_mismatch("mismatch", expected_samples[0], smp_if.sample_out);
                    void'(expected_samples.pop_front());
                end else begin
                    void'(expected_samples.pop_front());
                end
                sample_count++;
                recv_wait = recv_stalls ? $urandom_range(0, 3) : 0;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                smp_if.ready <= 1'b0;
            end else begin
                smp_if.ready <= 1'b1;
            end
        end
    end

    // APB write: setup, then access until pready
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            mwnco_pkg::REG_PHASE_STEP:  nco_cfg.phase_step  = value;
            mwnco_pkg::REG_AMPLITUDE:   nco_cfg.amplitude   = value[15:0];
            mwnco_pkg::REG_WAVE_SELECT: nco_cfg.wave_select = value[1:0];
            default:                    nco_cfg.pulse_limit = value;
        endcase
    endtask

    task automatic set_config(input logic [31:0] step, input logic [31:0] amp,
                              input logic [31:0] wave, input logic [31:0] limit);
        write_reg(mwnco_pkg::REG_PHASE_STEP, step);
        write_reg(mwnco_pkg::REG_AMPLITUDE, amp);
        write_reg(mwnco_pkg::REG_WAVE_SELECT, wave);
        write_reg(mwnco_pkg::REG_PULSE_LIMIT, limit);
    endtask

    // wait for all ticks taken and all samples back, then let the pipe empty
    task automatic settle();
        int guard;
        guard = 0;
        do begin
            @(negedge i_clk);
            guard++;
        end while ((pending_ticks.size() != 0 || req_if.valid ||
                    expected_samples.size() != 0) && guard < SETTLE_LIMIT);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(1, 1 << 24));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'd65535;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // timeout
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        logic [15:0] gain;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.sample_request = 1'b0;
        smp_if.ready = 1'b0;
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        mismatch_count = 0;
        sample_count = 0;
        phase_acc = '0;
        nco_cfg.phase_step  = mwnco_pkg::PHASE_STEP_RST;
        nco_cfg.amplitude   = mwnco_pkg::AMPLITUDE_RST;
        nco_cfg.wave_select = mwnco_pkg::WAVE_SELECT_RST;
        nco_cfg.pulse_limit = mwnco_pkg::PULSE_LIMIT_RST;

        // quarter sine at bin centers, Horner form in Q30, truncating products
        for (int a = 0; a < TABLE_SIZE; a++) begin
            u  = 64'(2 * a + 1) << 19;
            u2 = (u * u) >> 30;
            r  = TAYLOR_C11;
            r  = TAYLOR_C9 - ((r * u2) >> 30);
            r  = TAYLOR_C7 - ((r * u2) >> 30);
            r  = TAYLOR_C5 - ((r * u2) >> 30);
            r  = TAYLOR_C3 - ((r * u2) >> 30);
            r  = TAYLOR_C1 - ((r * u2) >> 30);
            r  = (r * u) >> 30;
            sine_quarter[a] = int'((r * 64'd32767 + (64'd1 << 29)) >> 30);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, with an empty tick in the middle
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        settle();

        // one tick that brings the phase back to zero
        set_config(32'h0 - phase_acc, 32'd32768, {30'd0, mwnco_pkg::WAVE_PULSE},
                   32'h4000_0000);
        pending_ticks.push_back(1'b1);
        settle();

        // quarter-turn steps: pulse at unit gain, edge exactly at the limit
        set_config(32'h4000_0000, 32'd32768, {30'd0, mwnco_pkg::WAVE_PULSE},
                   32'h4000_0000);
        repeat (4) pending_ticks.push_back(1'b1);
        settle();

        // full-scale triangle at unit gain
        set_config(32'h4000_0000, 32'd32768, {30'd0, mwnco_pkg::WAVE_TRIANGLE},
                   32'h4000_0000);
        repeat (4) pending_ticks.push_back(1'b1);
        settle();

        // sawtooth with gain above one
        set_config(32'h4000_0000, 32'd65535, {30'd0, mwnco_pkg::WAVE_SAWTOOTH},
                   32'h4000_0000);
        repeat (4) pending_ticks.push_back(1'b1);
        settle();

        // sine across all quadrants, mirrored index in odd ones
        set_config(32'h4010_0000, 32'd32768, {30'd0, mwnco_pkg::WAVE_SINE},
                   32'h4000_0000);
        repeat (4) pending_ticks.push_back(1'b1);
        settle();

        // junk in the upper bits: zero gain, pulse, never high
        set_config(32'h4010_0000, 32'hABCD_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        repeat (2) pending_ticks.push_back(1'b1);
        settle();

        // pulse always high, top gain, largest step
        set_config(32'hFFFF_FFFF, 32'd65535, {30'd0, mwnco_pkg::WAVE_PULSE},
                   32'hFFFF_FFFF);
        repeat (2) pending_ticks.push_back(1'b1);
        settle();

        // random settings, each followed by a burst of mostly live ticks
        for (int ph = 0; ph < 12; ph++) begin
            gain = pick_gain();
            set_config(pick_word(), {16'($urandom()), gain},
                       {$urandom() & 32'hFFFF_FFFC} | 32'($urandom_range(0, 3)),
                       pick_word());
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            repeat (40) pending_ticks.push_back($urandom_range(0, 4) != 0);
            settle();
        end

        if (expected_samples.size() != 0) begin
            mismatch_count++;
            $display("%0d samples never arrived", expected_samples.size());
        end
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
